// File: rtl/matrix3x3_inverse_adjugate_macros.svh
// assertion macros shared by the matrix inverse checker
// depends on nothing; include guard below
`ifndef MATRIX3X3_INVERSE_ADJUGATE_MACROS_SVH
`define MATRIX3X3_INVERSE_ADJUGATE_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define MIA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define MIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mia_pkg.sv
// types and constants for the 3x3 fixed-point matrix inverse
// used by mia_div, matrix3x3_inverse_adjugate and mia_checker
package mia_pkg;

   // number format and derived widths
   localparam int FRAC_BITS = 16;
   localparam int NE   = 9;                        // matrix entries
   localparam int MW   = 32;                       // entry width
   localparam int AW   = 2 * MW;                   // cofactor width
   localparam int DETW = AW + MW + 1;              // signed determinant
   localparam int DW   = DETW - 1;                 // determinant magnitude
   localparam int NW   = AW + 2 * FRAC_BITS;       // dividend width
   localparam int QB   = MW;                       // quotient bits kept
   localparam int RW   = (NW > DW + QB) ? NW : DW + QB;
   localparam int NS   = QB + 1;                   // divider stages

   localparam logic [MW-1:0] SAT_POS = {1'b0, {(MW-1){1'b1}}};
   localparam logic [MW-1:0] SAT_NEG = {1'b1, {(MW-1){1'b0}}};

   typedef struct packed {
      logic signed [MW-1:0] in_m00;
      logic signed [MW-1:0] in_m01;
      logic signed [MW-1:0] in_m02;
      logic signed [MW-1:0] in_m10;
      logic signed [MW-1:0] in_m11;
      logic signed [MW-1:0] in_m12;
      logic signed [MW-1:0] in_m20;
      logic signed [MW-1:0] in_m21;
      logic signed [MW-1:0] in_m22;
   } req_type;

   typedef struct packed {
      logic signed [MW-1:0] out_m00;
      logic signed [MW-1:0] out_m01;
      logic signed [MW-1:0] out_m02;
      logic signed [MW-1:0] out_m10;
      logic signed [MW-1:0] out_m11;
      logic signed [MW-1:0] out_m12;
      logic signed [MW-1:0] out_m20;
      logic signed [MW-1:0] out_m21;
      logic signed [MW-1:0] out_m22;
      logic                 singular;
      logic                 overflow;
   } rsp_type;

   // into the divider: magnitudes, signs, shared divisor
   typedef struct packed {
      logic [NE-1:0][NW-1:0] num;
      logic [NE-1:0]         neg;
      logic [DW-1:0]         den;
      logic                  sing;
   } div_in_type;

   // out of the divider: truncated quotients and range flags
   typedef struct packed {
      logic [NE-1:0][QB-1:0] quo;
      logic [NE-1:0]         big;
      logic [NE-1:0]         neg;
      logic                  sing;
   } div_out_type;

endpackage

// File: rtl/mia_div.sv
// pipelined restoring divider, nine lanes sharing one divisor, one bit per stage
// depends on mia_pkg
module mia_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  mia_pkg::div_in_type  div_in,
   output logic                 out_valid,
   output mia_pkg::div_out_type div_out
);
   import mia_pkg::*;

   logic [NS-1:0] v_ff, v_in;
   logic [RW-1:0] r_ff [NS][NE];
   logic [RW-1:0] r_in [NS][NE];
   logic [QB-1:0] q_ff [NS][NE];
   logic [QB-1:0] q_in [NS][NE];
   logic [NE-1:0] big_ff [NS];
   logic [NE-1:0] big_in [NS];
   logic [NE-1:0] neg_ff [NS];
   logic [NE-1:0] neg_in [NS];
   logic [DW-1:0] den_ff [NS];
   logic [DW-1:0] den_in [NS];
   logic [NS-1:0] sing_ff, sing_in;

   // first stage checks the quotient against 2^QB, later stages resolve one bit each
   always_comb begin
      logic [RW-1:0] src_r;
      logic [QB-1:0] src_q;
      logic [RW-1:0] sh;
      logic          ge;
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            v_in[s]    = in_valid;
            den_in[s]  = div_in.den;
            neg_in[s]  = div_in.neg;
            sing_in[s] = div_in.sing;
         end else begin
            v_in[s]    = v_ff[s-1];
            den_in[s]  = den_ff[s-1];
            neg_in[s]  = neg_ff[s-1];
            sing_in[s] = sing_ff[s-1];
         end
         for (int k = 0; k < NE; k++) begin
            if (s == 0) begin
               src_r = RW'(div_in.num[k]);
               src_q = '0;
            end else begin
               src_r = r_ff[s-1][k];
               src_q = q_ff[s-1][k];
            end
            sh = RW'(den_in[s]) << (QB - s);
            ge = (src_r >= sh);
            if (s == 0) begin
               r_in[s][k]   = src_r;
               q_in[s][k]   = '0;
               big_in[s][k] = ge;
            end else begin
               r_in[s][k]   = ge ? src_r - sh : src_r;
               q_in[s][k]   = src_q | (QB'(ge) << (QB - s));
               big_in[s][k] = big_ff[s-1][k];
            end
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff    <= r_in;
         q_ff    <= q_in;
         big_ff  <= big_in;
         neg_ff  <= neg_in;
         den_ff  <= den_in;
         sing_ff <= sing_in;
      end
   end

   // last stage drives the result
   always_comb begin
      out_valid    = v_ff[NS-1];
      div_out.big  = big_ff[NS-1];
      div_out.neg  = neg_ff[NS-1];
      div_out.sing = sing_ff[NS-1];
      for (int k = 0; k < NE; k++) begin
         div_out.quo[k] = q_ff[NS-1][k];
      end
   end

endmodule

// File: rtl/matrix3x3_inverse_adjugate.sv
// 3x3 signed fixed-point matrix inverse by the adjugate, fully pipelined
// depends on mia_pkg and mia_div
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_ready  mia_pkg::req_type, nine entries
//   rsp       out         rsp_valid/rsp_ready  mia_pkg::rsp_type, inverse + flags
//
// one matrix per cycle while no result is stalled; the pipeline is 8 stages of cofactor and
// determinant math, 33 stages of the one-bit-per-stage divider, one output register.
// the divider depth (quotient bits plus range check) sets the latency.
// reset clears every stage valid bit; no result is pending after reset.
// a stalled result holds the whole pipeline; nothing moves until it is taken.
module matrix3x3_inverse_adjugate (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mia_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mia_pkg::rsp_type rsp_payload
);
   import mia_pkg::*;

   // cofactor k = m[PA]*m[PB] - m[PC]*m[PD]
   localparam int unsigned PA [NE] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int unsigned PB [NE] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int unsigned PC [NE] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
   localparam int unsigned PD [NE] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

   logic adv;
   logic [7:0] v_ff;
   logic       div_valid;
   logic       rsp_v_ff;

   logic signed [MW-1:0]   m_ff [NE], m_in [NE];
   logic signed [AW-1:0]   prod_ff [2*NE], prod_in [2*NE];
   logic signed [MW-1:0]   r1_ff [3], r2_ff [3];
   logic signed [AW-1:0]   adj2_ff [NE], adj2_in [NE];
   logic signed [AW-1:0]   adj3_ff [NE], adj4_ff [NE], adj5_ff [NE], adj6_ff [NE];
   logic signed [AW-1:0]   phi_ff [3], phi_in [3];
   logic signed [AW:0]     plo_ff [3], plo_in [3];
   logic signed [DETW-1:0] term_ff [3], term_in [3];
   logic signed [DETW-1:0] s01_ff, t2_ff, det_ff;
   div_in_type             div_in_ff, div_in_in;
   div_out_type            div_out;
   logic [MW-1:0]          res [NE];
   logic                   ovf;
   rsp_type                rsp_ff, rsp_in;

   // the whole pipeline moves unless a finished result is waiting
   assign adv       = !rsp_v_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_v_ff;
   assign rsp_payload = rsp_ff;

   // unpack the request
   always_comb begin
      m_in[0] = req_payload.in_m00;
      m_in[1] = req_payload.in_m01;
      m_in[2] = req_payload.in_m02;
      m_in[3] = req_payload.in_m10;
      m_in[4] = req_payload.in_m11;
      m_in[5] = req_payload.in_m12;
      m_in[6] = req_payload.in_m20;
      m_in[7] = req_payload.in_m21;
      m_in[8] = req_payload.in_m22;
   end

   // cofactor products and differences
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         prod_in[2*k]   = m_ff[PA[k]] * m_ff[PB[k]];
         prod_in[2*k+1] = m_ff[PC[k]] * m_ff[PD[k]];
         adj2_in[k]     = prod_ff[2*k] - prod_ff[2*k+1];
      end
   end

   // determinant along the first row, 64-bit cofactor split in two halves
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         phi_in[j]  = r2_ff[j] * $signed(adj2_ff[3*j][AW-1:MW]);
         plo_in[j]  = r2_ff[j] * $signed({1'b0, adj2_ff[3*j][MW-1:0]});
         term_in[j] = {{(DETW-AW-MW){phi_ff[j][AW-1]}}, phi_ff[j], {MW{1'b0}}}
                    + {{(DETW-AW-1){plo_ff[j][AW]}}, plo_ff[j]};
      end
   end

   // magnitudes, signs and divisor for the divider
   always_comb begin
      logic signed [AW-1:0] a;
      logic [AW-1:0]        amag;
      for (int k = 0; k < NE; k++) begin
         a    = adj6_ff[k];
         amag = a[AW-1] ? AW'(-a) : AW'(a);
         div_in_in.num[k] = NW'(amag) << (2 * FRAC_BITS);
         div_in_in.neg[k] = a[AW-1] ^ det_ff[DETW-1];
      end
      div_in_in.den  = det_ff[DETW-1] ? DW'(-det_ff) : DW'(det_ff);
      div_in_in.sing = (det_ff == '0);
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[6:0], req_valid};
         rsp_v_ff <= div_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff      <= m_in;
         prod_ff   <= prod_in;
         r1_ff     <= m_ff[0:2];
         r2_ff     <= r1_ff;
         adj2_ff   <= adj2_in;
         adj3_ff   <= adj2_ff;
         phi_ff    <= phi_in;
         plo_ff    <= plo_in;
         adj4_ff   <= adj3_ff;
         term_ff   <= term_in;
         adj5_ff   <= adj4_ff;
         s01_ff    <= term_ff[0] + term_ff[1];
         t2_ff     <= term_ff[2];
         adj6_ff   <= adj5_ff;
         det_ff    <= s01_ff + t2_ff;
         div_in_ff <= div_in_in;
         rsp_ff    <= rsp_in;
      end
   end

   mia_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v_ff[7]),
      .div_in    (div_in_ff),
      .out_valid (div_valid),
      .div_out   (div_out)
   );

   // saturate, restore sign, zero on singular
   always_comb begin
      logic [QB-1:0] lim;
      logic [QB-1:0] mag;
      logic [NE-1:0] sat;
      for (int k = 0; k < NE; k++) begin
         lim    = div_out.neg[k] ? SAT_NEG : SAT_POS;
         sat[k] = div_out.big[k] || (div_out.quo[k] > lim);
         mag    = sat[k] ? lim : div_out.quo[k];
         res[k] = div_out.sing ? '0 : (div_out.neg[k] ? MW'(-mag) : MW'(mag));
      end
      ovf = (|sat) && !div_out.sing;
   end

   // pack the response
   always_comb begin
      rsp_in.out_m00  = res[0];
      rsp_in.out_m01  = res[1];
      rsp_in.out_m02  = res[2];
      rsp_in.out_m10  = res[3];
      rsp_in.out_m11  = res[4];
      rsp_in.out_m12  = res[5];
      rsp_in.out_m20  = res[6];
      rsp_in.out_m21  = res[7];
      rsp_in.out_m22  = res[8];
      rsp_in.singular = div_out.sing;
      rsp_in.overflow = ovf;
   end

endmodule

// File: rtl/mia_checker.sv
// port-level checks for the matrix inverse, bound to the top level
// depends on mia_pkg and matrix3x3_inverse_adjugate_macros.svh
`include "matrix3x3_inverse_adjugate_macros.svh"

module mia_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mia_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mia_pkg::rsp_type rsp_payload
);
   import mia_pkg::*;

   logic unused_in;
   assign unused_in = req_valid ^ (|req_payload);

   // a singular result carries zeros and no overflow
   `MIA_ASSERT_NOW(a_singular_zero, clock, reset, rsp_valid && rsp_payload.singular, !rsp_payload.overflow && rsp_payload.out_m00 == 0 && rsp_payload.out_m01 == 0 && rsp_payload.out_m02 == 0 && rsp_payload.out_m10 == 0 && rsp_payload.out_m11 == 0 && rsp_payload.out_m12 == 0 && rsp_payload.out_m20 == 0 && rsp_payload.out_m21 == 0 && rsp_payload.out_m22 == 0, "singular result not cleared")

   // a waiting result blocks new transfers
   `MIA_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "input taken while result stalled")

   // reset leaves nothing pending
   `MIA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result pending after reset")

   // a stalled result holds
   `MIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")

endmodule

bind matrix3x3_inverse_adjugate mia_checker u_mia_checker (.*);

// File: tb/tb_matrix3x3_inverse_adjugate.sv
// self-checking testbench for the 3x3 fixed-point matrix inverse
// depends on mia_pkg and matrix3x3_inverse_adjugate; exact inverse predictor inside
module tb_matrix3x3_inverse_adjugate;
   import mia_pkg::*;

   localparam int PIPE_DEPTH = 42;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   rsp_type expected_inverses[$];
   int      mismatch_count = 0;
   int      unexpected_count = 0;
   int      transfers_in = 0;
   int      transfers_out = 0;
   int      singular_seen = 0;
   int      overflow_seen = 0;
   int      req_stall_cycles = 0;
   int      sender_steady = 0;   // 1: no gaps between transfers
   int      receiver_steady = 0; // 1: always ready
   int      hold_request = 0;    // cycles of forced receiver hold-off

   matrix3x3_inverse_adjugate u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // exact inverse: adjugate over determinant, truncated toward zero, saturated
   function automatic rsp_type predict_inverse(req_type m);
      logic signed [63:0]  ent[9];
      logic signed [63:0]  cof[9];
      logic signed [127:0] wide_ent[3];
      logic signed [127:0] wide_cof[3];
      logic signed [127:0] det;
      logic [127:0]        det_mag;
      logic [63:0]         cof_mag;
      logic [127:0]        quo;
      logic [31:0]         lim;
      logic [31:0]         res[9];
      logic                det_neg;
      logic                neg;
      logic                ovf;
      rsp_type             r;
      ent[0] = m.in_m00; ent[1] = m.in_m01; ent[2] = m.in_m02;
      ent[3] = m.in_m10; ent[4] = m.in_m11; ent[5] = m.in_m12;
      ent[6] = m.in_m20; ent[7] = m.in_m21; ent[8] = m.in_m22;
      // cofactors wrap at 64 bits like the datapath
      cof[0] = ent[4] * ent[8] - ent[7] * ent[5];
      cof[1] = ent[7] * ent[2] - ent[1] * ent[8];
      cof[2] = ent[1] * ent[5] - ent[4] * ent[2];
      cof[3] = ent[6] * ent[5] - ent[3] * ent[8];
      cof[4] = ent[0] * ent[8] - ent[6] * ent[2];
      cof[5] = ent[3] * ent[2] - ent[0] * ent[5];
      cof[6] = ent[3] * ent[7] - ent[6] * ent[4];
      cof[7] = ent[6] * ent[1] - ent[0] * ent[7];
      cof[8] = ent[0] * ent[4] - ent[3] * ent[1];
      for (int i = 0; i < 3; i++) begin
         wide_ent[i] = ent[i];
         wide_cof[i] = cof[3 * i];
      end
      det = wide_ent[0] * wide_cof[0] + wide_ent[1] * wide_cof[1]
          + wide_ent[2] * wide_cof[2];
      det_neg = det[127];
      det_mag = det_neg ? -det : det;
      r = '0;
      if (det_mag == '0) begin
         r.singular = 1'b1;
         return r;
      end
      ovf = 1'b0;
      for (int k = 0; k < 9; k++) begin
         neg = cof[k][63] != det_neg;
         cof_mag = cof[k][63] ? -cof[k] : cof[k];
         quo = ({64'd0, cof_mag} << (2 * FRAC_BITS)) / det_mag;
         lim = neg ? SAT_NEG : SAT_POS;
         if (quo > {96'd0, lim}) begin
            quo = {96'd0, lim};
            ovf = 1'b1;
         end
         res[k] = neg ? -quo[31:0] : quo[31:0];
      end
      r.out_m00 = res[0]; r.out_m01 = res[1]; r.out_m02 = res[2];
      r.out_m10 = res[3]; r.out_m11 = res[4]; r.out_m12 = res[5];
      r.out_m20 = res[6]; r.out_m21 = res[7]; r.out_m22 = res[8];
      r.overflow = ovf;
      return r;
   endfunction

   function automatic logic [31:0] entry_of(rsp_type r, int k);
      return r[$bits(rsp_type) - 1 - 32 * k -: 32];
   endfunction

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one matrix and hold it until the transfer
   task automatic send_matrix(req_type m);
      int gap;
      req_payload <= m;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         req_stall_cycles++;
         @(posedge clock);
      end
      expected_inverses.push_back(predict_inverse(m));
      transfers_in++;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver ready: random stalls, steady stretches, forced hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            hold_request--;
         end else if (receiver_steady) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // result check against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_r;
      logic    bad;
      if (!reset && rsp_valid && rsp_ready) begin
         transfers_out++;
         if (expected_inverses.size() == 0) begin
            unexpected_count++;
            if (unexpected_count + mismatch_count <= 10)
               $display("unexpected result transfer: %h", rsp_payload);
         end else begin
            exp_r = expected_inverses.pop_front();
            bad = 1'b0;
            for (int k = 0; k < 9; k++) begin
               if (entry_of(rsp_payload, k) !== entry_of(exp_r, k)) begin
                  bad = 1'b1;
                  if (mismatch_count < 10)
                     $display("out_m%0d%0d: expected %h got %h", k / 3, k % 3,
                              entry_of(exp_r, k), entry_of(rsp_payload, k));
               end
            end
            if (rsp_payload.singular !== exp_r.singular) begin
               bad = 1'b1;
               if (mismatch_count < 10)
                  $display("singular: expected %b got %b", exp_r.singular,
                           rsp_payload.singular);
            end
            if (rsp_payload.overflow !== exp_r.overflow) begin
               bad = 1'b1;
               if (mismatch_count < 10)
                  $display("overflow: expected %b got %b", exp_r.overflow,
                           rsp_payload.overflow);
            end
            if (exp_r.singular) singular_seen++;
            if (exp_r.overflow) overflow_seen++;
            if (bad) mismatch_count++;
         end
      end
   end

   function automatic req_type make_matrix(logic [31:0] a0, logic [31:0] a1,
                                           logic [31:0] a2, logic [31:0] a3,
                                           logic [31:0] a4, logic [31:0] a5,
                                           logic [31:0] a6, logic [31:0] a7,
                                           logic [31:0] a8);
      req_type m;
      m.in_m00 = a0; m.in_m01 = a1; m.in_m02 = a2;
      m.in_m10 = a3; m.in_m11 = a4; m.in_m12 = a5;
      m.in_m20 = a6; m.in_m21 = a7; m.in_m22 = a8;
      return m;
   endfunction

   // entry within about +-4.0
   function automatic logic [31:0] modest_entry();
      return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
   endfunction

   function automatic req_type random_matrix(int kind);
      req_type m;
      logic [31:0] e[9];
      for (int k = 0; k < 9; k++)
         case (kind)
            0: e[k] = modest_entry();
            1: e[k] = $urandom();
            default: e[k] = $urandom_range(0, 32'h0000_0400) - 32'h0000_0200;
         endcase
      m = make_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
      return m;
   endfunction

   // edge values, identity, singular shapes, saturation
   task automatic test_directed();
      localparam logic [31:0] ONE = 32'h0001_0000;
      localparam logic [31:0] MX  = 32'h7FFF_FFFF;
      localparam logic [31:0] MN  = 32'h8000_0000;
      send_matrix(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix(make_matrix(32'h0002_0000, 0, 0, 0, 32'hFFFE_0000, 0, 0, 0,
                              32'h0000_8000));
      send_matrix('0);
      send_matrix(make_matrix(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE,
                              5, 7, 9));
      send_matrix(make_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
      send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(make_matrix(MX, 0, 0, 0, MX, 0, 0, 0, MX));
      send_matrix(make_matrix(MN, 0, 0, 0, MN, 0, 0, 0, MN));
      send_matrix(make_matrix(MX, MX, MX, MX, MX, MX, MX, MX, MX));
      send_matrix(make_matrix(MN, MN, MN, MN, MN, MN, MN, MN, MN));
      send_matrix(make_matrix(MX, MN, MX, MN, MX, MN, MX, MN, MX));
      send_matrix(make_matrix(MN, MX, 0, MX, MN, 0, 0, 0, MN));
      send_matrix(make_matrix(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
                              32'h5555_5555, 32'hAAAA_AAAA, 1, 32'hFFFF_FFFF, 1,
                              32'h5555_5555));
      send_matrix(make_matrix(32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0,
                              32'hFFFF_FFFF));
      send_matrix(make_matrix(ONE, ONE, 0, ONE, ONE + 1, 0, 0, 0, ONE));
      send_matrix(make_matrix(MN, MN, 0, MX, MN, 0, 0, 0, ONE));
      send_matrix(make_matrix(3 * ONE, ONE, 2 * ONE, 32'hFFFF_0000, 4 * ONE,
                              ONE, 2 * ONE, 32'hFFFD_0000, 5 * ONE));
   endtask

   // mostly well-conditioned matrices, with full-range noise and tiny entries
   task automatic test_random_mix(int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         send_matrix(random_matrix(roll < 65 ? 0 : (roll < 85 ? 1 : 2)));
      end
   endtask

   // rank-deficient matrices: repeated row, repeated column, or zero row
   task automatic test_singular(int count);
      req_type m;
      for (int i = 0; i < count; i++) begin
         m = random_matrix($urandom_range(0, 1));
         case ($urandom_range(0, 2))
            0: begin
               m.in_m20 = m.in_m00; m.in_m21 = m.in_m01; m.in_m22 = m.in_m02;
            end
            1: begin
               m.in_m01 = m.in_m00; m.in_m11 = m.in_m10; m.in_m21 = m.in_m20;
            end
            default: begin
               m.in_m10 = '0; m.in_m11 = '0; m.in_m12 = '0;
            end
         endcase
         send_matrix(m);
      end
   endtask

   // back-to-back transfers both sides
   task automatic test_full_rate(int count);
      sender_steady   = 1;
      receiver_steady = 1;
      test_random_mix(count);
      sender_steady   = 0;
      receiver_steady = 0;
   endtask

   // receiver holds off long enough for the pipeline to fill and stall input
   task automatic test_backpressure(int count);
      sender_steady = 1;
      hold_request  = 300;
      test_random_mix(count);
      sender_steady = 0;
   endtask

   // stimulus sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mix(400);
      test_singular(80);
      test_full_rate(150);
      test_backpressure(120);
      test_random_mix(100);
      req_valid <= 1'b0;
      while (expected_inverses.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      $display("matrices in %0d, results out %0d (singular %0d, saturated %0d)",
               transfers_in, transfers_out, singular_seen, overflow_seen);
      $display("input stalled %0d cycles; mismatches %0d, unexpected %0d",
               req_stall_cycles, mismatch_count, unexpected_count);
      if (mismatch_count == 0 && unexpected_count == 0 &&
          expected_inverses.size() == 0)
         $display("tb_matrix3x3_inverse_adjugate: PASS");
      else
         $display("tb_matrix3x3_inverse_adjugate: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #(8 * 200000);
      $display("timeout with %0d results outstanding", expected_inverses.size());
      $display("tb_matrix3x3_inverse_adjugate: FAIL");
      $finish;
   end

endmodule
